@@ sv/tksrt_pkg.sv @@
// Package for the top-k size ranking table.
// Holds the table depth, the operation codes, the request and response
// structs and the command struct from the sequencer to the slot store.
package tksrt_pkg;

  localparam int SLOTS = 10;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W = 16;
  localparam int SIZE_W = 16;
  localparam int RANK_W = 4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   net_id;
    logic [SIZE_W-1:0] net_size;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              found;
  } rsp_t;

  typedef struct packed {
    logic              clear;
    logic              insert;
    logic [IDX_W-1:0]  pos;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } store_cmd_t;

endpackage

@@ sv/tksrt_store.sv @@
// Slot store of the ranking table: SLOTS (id, size) pairs in flip-flops.
// One read port at the scan index; clear and insert-with-shift commands.
// Depends on tksrt_pkg.
module tksrt_store (
  input  logic                                clk,
  input  logic                                rst,
  input  tksrt_pkg::store_cmd_t               cmd,
  input  logic [tksrt_pkg::IDX_W-1:0]         rd_idx,
  output logic [tksrt_pkg::ID_W-1:0]          rd_id,
  output logic [tksrt_pkg::SIZE_W-1:0]        rd_size
);
  import tksrt_pkg::*;

  logic [ID_W-1:0]   ids   [SLOTS];
  logic [SIZE_W-1:0] sizes [SLOTS];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int m = 0; m < SLOTS; m++) begin
        ids[m]   <= '0;
        sizes[m] <= '0;
      end
    end else if (cmd.insert) begin
      // shift every slot below the insert point down one; last drops off
      for (int m = 1; m < SLOTS; m++) begin
        if (IDX_W'(m) > cmd.pos) begin
          ids[m]   <= ids[m-1];
          sizes[m] <= sizes[m-1];
        end
      end
      ids[cmd.pos]   <= cmd.id;
      sizes[cmd.pos] <= cmd.size;
    end
  end

  assign rd_id   = ids[rd_idx];
  assign rd_size = sizes[rd_idx];

endmodule

@@ sv/tksrt_seq.sv @@
// Sequencer of the ranking table: takes a request, walks the slots one per
// cycle through a single compare unit, and registers the response.
// Depends on tksrt_pkg.
module tksrt_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  tksrt_pkg::req_t               req,
  input  logic                          req_valid,
  output logic                          req_ready,
  output tksrt_pkg::rsp_t               rsp,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output tksrt_pkg::store_cmd_t         cmd,
  output logic [tksrt_pkg::IDX_W-1:0]   rd_idx,
  input  logic [tksrt_pkg::ID_W-1:0]    rd_id,
  input  logic [tksrt_pkg::SIZE_W-1:0]  rd_size
);
  import tksrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t            state;
  logic [1:0]        kind;
  logic [ID_W-1:0]   id;
  logic [SIZE_W-1:0] size;
  logic [IDX_W-1:0]  idx;
  logic [RANK_W-1:0] rank;
  logic              found;
  logic              match;

  // shared compare: size order for add, id equality for lookup
  assign match = (kind == KIND_ADD) ? (size > rd_size) : (id == rd_id);

  assign rd_idx    = idx;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.clear  = (state == S_SCAN) && (kind == KIND_CLEAR);
    cmd.insert = (state == S_SCAN) && (kind == KIND_ADD) && match;
    cmd.pos    = idx;
    cmd.id     = id;
    cmd.size   = size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // drop the taken response; the finish state reloads it instead
      if (rsp_valid && rsp_ready && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind  <= req.kind;
            id    <= req.net_id;
            size  <= req.net_size;
            idx   <= '0;
            rank  <= '0;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          case (kind)
            KIND_ADD: begin
              if (match || idx == LAST_IDX) begin
                state <= S_FINISH;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            KIND_LOOKUP: begin
              if (match) begin
                found <= 1'b1;
                rank  <= RANK_W'(idx);
                state <= S_FINISH;
              end else if (idx == LAST_IDX) begin
                state <= S_FINISH;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end
        S_FINISH: begin
          // hold until the response register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid  <= 1'b1;
            rsp.rank   <= rank;
            rsp.found  <= found;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/top_k_size_ranking_table.sv @@
// Top level of the top-k size ranking table: sequencer plus slot store.
// Depends on tksrt_pkg, tksrt_seq and tksrt_store.
//
//   channel   direction   handshake               payload
//   request   in          req_valid / req_ready   req  (kind, net_id, net_size)
//   response  out         rsp_valid / rsp_ready   rsp  (rank, found)
//
// Flow: a request is accepted in the idle state, scanned one slot per cycle
// through the shared compare unit (a clear issues its command in the scan
// state), and loaded into the response register in the finish state.
// An add writes the new pair and shifts the later slots in the cycle its
// insert point is found. Reset clears every slot to id 0, size 0 at once.
// A new request is taken while an earlier response still waits; its own
// response then holds in the sequencer until the response register frees.
module top_k_size_ranking_table (
  input  logic             clk,
  input  logic             rst,
  input  tksrt_pkg::req_t  req,
  input  logic             req_valid,
  output logic             req_ready,
  output tksrt_pkg::rsp_t  rsp,
  output logic             rsp_valid,
  input  logic             rsp_ready
);
  import tksrt_pkg::*;

  store_cmd_t        cmd;
  logic [IDX_W-1:0]  rd_idx;
  logic [ID_W-1:0]   rd_id;
  logic [SIZE_W-1:0] rd_size;

  // sequencer: owns the handshakes, the scan index and the compare
  tksrt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .rd_id     (rd_id),
    .rd_size   (rd_size)
  );

  // slot store: sorted pairs, read at the scan index
  tksrt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .rd_id   (rd_id),
    .rd_size (rd_size)
  );

endmodule

@@ sv/tksrt_checker.sv @@
// Port-level checks for the ranking table, bound to the top level.
// Depends on tksrt_pkg.
module tksrt_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input tksrt_pkg::rsp_t  rsp,
  input logic             rsp_valid,
  input logic             rsp_ready
);
  import tksrt_pkg::*;

  // a stalled response holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // an accepted request keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken in back-to-back cycles");

  // a miss or a non-lookup reports rank zero
  a_miss_rank: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.rank == '0)
    else $error("rank nonzero without a hit");

  // a hit names a slot that exists
  a_hit_rank: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> (SLOTS > 16) || (rsp.rank < RANK_W'(SLOTS)))
    else $error("hit rank beyond the table");

  // no response straight out of reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind top_k_size_ranking_table tksrt_checker u_tksrt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready)
);
